// ===== sv/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// shared constants of the biquadratic root solver
// ----------------------------------------------------------------------------
package brs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COEF_W    = 16;
  localparam int ROOT_W    = 26;
  localparam int STATUS_W  = 3;

  localparam logic [ROOT_W-1:0]   ROOT_MAX     = 26'h1FF_FFFF;
  localparam logic [STATUS_W-1:0] STATUS_NONE  = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDET = 3'd5;

endpackage

// ===== sv/biquadratic_root_solver_top.sv =====
// ----------------------------------------------------------------------------
// biquadratic_root_solver_top
// real roots of a*x^4 + b*x^2 + c = 0 in fixed point, fully pipelined
// ----------------------------------------------------------------------------
//  channel   dir  fields (tdata from bit 0)
//  s_axis    in   coef_quartic, coef_square, coef_constant
//  m_axis    out  root_status, root_one, root_two, root_three, root_four
//
//  one coefficient set per cycle while m_axis is not stalled; the depth is
//  set by the discriminant square root, the divider and the root square root,
//  each one bit per stage
//  rst_ni clears all valid bits at once; no clearing pass
//  a result held at m_axis freezes the whole pipeline; nothing is dropped
// ----------------------------------------------------------------------------
module biquadratic_root_solver_top
  import brs_pkg::*;
#(
  parameter int FracBits = FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // coef_quartic [15:0], coef_square [31:16], coef_constant [47:32]
  input  logic [47:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // root_status [2:0], root_one [28:3], root_two [54:29], root_three [80:55],
  // root_four [106:81], zero [111:107]
  output logic [111:0] m_axis_tdata_o
);

  localparam int SqW  = 17 + FracBits;   // discriminant root width
  localparam int NumW = FracBits + 19;   // signed numerator width
  localparam int QW   = FracBits + 18;   // quotient magnitude width
  localparam int DenW = 17;              // divisor magnitude width
  localparam int RtW  = FracBits + 9;    // root magnitude width
  localparam int CW   = (RtW > ROOT_W) ? RtW : ROOT_W;

  typedef struct packed {
    logic                      fixed;
    logic [STATUS_W-1:0]       fst;
    logic                      two_y;
    logic                      lin;
    logic signed [COEF_W-1:0]  a;
    logic signed [COEF_W-1:0]  b;
    logic signed [COEF_W-1:0]  c;
  } d_side_t;

  typedef struct packed {
    logic                fixed;
    logic [STATUS_W-1:0] fst;
    logic                two_y;
    logic                sgn1;
    logic                sgn2;
  } q_side_t;

  typedef struct packed {
    logic                fixed;
    logic [STATUS_W-1:0] fst;
    logic                two_y;
    logic                pos1;
    logic                zero1;
    logic                pos2;
    logic                zero2;
  } r_side_t;

  logic en;

  // stage 1: products
  logic                      vld1_q;
  logic signed [COEF_W-1:0]  a1_q, b1_q, c1_q;
  logic signed [31:0]        bb1_q, ac1_q;

  // stage 2: discriminant and case flags
  logic                vld2_q;
  logic signed [33:0]  d2_q;
  d_side_t             side2_q;
  logic signed [33:0]  d_c;
  d_side_t             side2_d;

  // discriminant root
  logic [2*SqW-1:0]    dsq_rad [1];
  logic [SqW-1:0]      dsq_root [1];
  logic [$bits(d_side_t)-1:0] dsq_side;
  logic                dsq_vld;
  d_side_t             ds;

  // stage 3: numerators and divisor as magnitudes
  logic                vld3_q;
  logic [QW-1:0]       nm_q [2];
  logic [DenW-1:0]     dm_q;
  q_side_t             side3_q;
  logic signed [NumW-1:0] bneg_c, cneg_c, sx_c, num1_c, num2_c;
  logic signed [17:0]  den_c;

  // divider
  logic [QW-1:0]       quot [2];
  logic [$bits(q_side_t)-1:0] div_side;
  logic                div_vld;
  q_side_t             qs;
  r_side_t             rs_d;
  logic [2*RtW-1:0]    rsq_rad [2];

  // root square roots
  logic [RtW-1:0]      rsq_root [2];
  logic [$bits(r_side_t)-1:0] rsq_side;
  logic                rsq_vld;
  r_side_t             rs;

  // output
  logic                out_vld_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [ROOT_W-1:0]   root_q [4];
  logic [ROOT_W-1:0]   root_d [4];
  logic [ROOT_W-1:0]   mag [2];

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= s_axis_tdata_i[15:0];
      b1_q  <= s_axis_tdata_i[31:16];
      c1_q  <= s_axis_tdata_i[47:32];
      bb1_q <= $signed(s_axis_tdata_i[31:16]) * $signed(s_axis_tdata_i[31:16]);
      ac1_q <= $signed(s_axis_tdata_i[15:0]) * $signed(s_axis_tdata_i[47:32]);
    end
  end

  // ---------------- stage 2 ----------------
  assign d_c = 34'(bb1_q) - (34'(ac1_q) <<< 2);

  always_comb begin
    side2_d       = '0;
    side2_d.a     = a1_q;
    side2_d.b     = b1_q;
    side2_d.c     = c1_q;
    side2_d.lin   = (a1_q == '0);
    side2_d.fst   = STATUS_NONE;
    if (a1_q == '0) begin
      if (b1_q == '0) begin
        side2_d.fixed = 1'b1;
        side2_d.fst   = (c1_q == '0) ? STATUS_UNDET : STATUS_NONE;
      end
    end else if (d_c < 0) begin
      side2_d.fixed = 1'b1;
    end else begin
      side2_d.two_y = (d_c != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q    <= d_c;
      side2_q <= side2_d;
    end
  end

  // radicand is D * 2^(2F); a negative D is never used
  assign dsq_rad[0] = (d2_q > 0) ? {1'b0, d2_q[32:0], {(2*FracBits){1'b0}}} : '0;

  brs_sqrt #(
    .RootW (SqW),
    .Lanes (1),
    .SideW ($bits(d_side_t))
  ) u_dsq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld2_q),
    .rad_i   (dsq_rad),
    .side_i  (side2_q),
    .valid_o (dsq_vld),
    .root_o  (dsq_root),
    .side_o  (dsq_side)
  );

  // ---------------- stage 3 ----------------
  assign ds     = d_side_t'(dsq_side);
  assign bneg_c = -(NumW'(ds.b) <<< FracBits);
  assign cneg_c = -(NumW'(ds.c) <<< FracBits);
  assign sx_c   = $signed(NumW'(dsq_root[0]));
  assign num1_c = ds.lin ? cneg_c : (bneg_c - sx_c);
  assign num2_c = bneg_c + sx_c;
  assign den_c  = ds.lin ? 18'(ds.b) : (18'(ds.a) <<< 1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      nm_q[0]       <= num1_c[NumW-1] ? QW'(-num1_c) : QW'(num1_c);
      nm_q[1]       <= num2_c[NumW-1] ? QW'(-num2_c) : QW'(num2_c);
      dm_q          <= den_c[17] ? DenW'(-den_c) : DenW'(den_c);
      side3_q.fixed <= ds.fixed;
      side3_q.fst   <= ds.fst;
      side3_q.two_y <= ds.two_y;
      side3_q.sgn1  <= num1_c[NumW-1] ^ den_c[17];
      side3_q.sgn2  <= num2_c[NumW-1] ^ den_c[17];
    end
  end

  brs_div #(
    .QuotW (QW),
    .DivW  (DenW),
    .Lanes (2),
    .SideW ($bits(q_side_t))
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld3_q),
    .num_i   (nm_q),
    .den_i   (dm_q),
    .side_i  (side3_q),
    .valid_o (div_vld),
    .quot_o  (quot),
    .side_o  (div_side)
  );

  // sign of y comes from the signs of numerator and divisor
  assign qs = q_side_t'(div_side);

  always_comb begin
    rs_d.fixed = qs.fixed;
    rs_d.fst   = qs.fst;
    rs_d.two_y = qs.two_y;
    rs_d.zero1 = (quot[0] == '0);
    rs_d.zero2 = (quot[1] == '0);
    rs_d.pos1  = !qs.sgn1 && !rs_d.zero1;
    rs_d.pos2  = !qs.sgn2 && !rs_d.zero2;
    rsq_rad[0] = rs_d.pos1 ? {quot[0], {FracBits{1'b0}}} : '0;
    rsq_rad[1] = rs_d.pos2 ? {quot[1], {FracBits{1'b0}}} : '0;
  end

  brs_sqrt #(
    .RootW (RtW),
    .Lanes (2),
    .SideW ($bits(r_side_t))
  ) u_rsq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .rad_i   (rsq_rad),
    .side_i  (rs_d),
    .valid_o (rsq_vld),
    .root_o  (rsq_root),
    .side_o  (rsq_side)
  );

  // ---------------- output stage ----------------
  assign rs = r_side_t'(rsq_side);

  always_comb begin
    logic [CW-1:0] wide;
    logic [1:0]    n1;
    for (int l = 0; l < 2; l++) begin
      wide = CW'(rsq_root[l]);
      if (wide > CW'(ROOT_MAX)) begin
        mag[l] = ROOT_MAX;
      end else begin
        mag[l] = wide[ROOT_W-1:0];
      end
    end
    for (int k = 0; k < 4; k++) begin
      root_d[k] = '0;
    end
    n1       = 2'd0;
    status_d = rs.fst;
    if (!rs.fixed) begin
      if (rs.pos1) begin
        root_d[0] = -mag[0];
        root_d[1] = mag[0];
        n1        = 2'd2;
      end else if (rs.zero1) begin
        n1 = 2'd1;
      end
      status_d = STATUS_W'(n1);
      if (rs.two_y) begin
        if (rs.pos2) begin
          root_d[n1]        = -mag[1];
          root_d[n1 + 2'd1] = mag[1];
          status_d          = STATUS_W'(n1) + 3'd2;
        end else if (rs.zero2) begin
          status_d = STATUS_W'(n1) + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= status_d;
      root_q   <= root_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld1_q    <= s_axis_tvalid_i;
      vld2_q    <= vld1_q;
      vld3_q    <= dsq_vld;
      out_vld_q <= rsq_vld;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'b0, root_q[3], root_q[2], root_q[1], root_q[0], status_q};

  // ---------------- assertions ----------------
  a_undet_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (status_q == STATUS_UNDET) |->
      (root_q[0] == '0) && (root_q[1] == '0) && (root_q[2] == '0) && (root_q[3] == '0))
    else $error("undetermined result with nonzero roots");

  a_none_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (status_q == STATUS_NONE) |->
      (root_q[0] == '0) && (root_q[1] == '0) && (root_q[2] == '0) && (root_q[3] == '0))
    else $error("result without roots has nonzero slots");

  a_pair_mirror : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ((status_q == 3'd2) || (status_q == 3'd4)) |->
      (root_q[1] == ROOT_W'(-root_q[0])))
    else $error("first root pair is not symmetric");

endmodule

// ===== sv/brs_sqrt.sv =====
// ----------------------------------------------------------------------------
// brs_sqrt
// pipelined floor square root, one root bit per stage, several lanes
// ----------------------------------------------------------------------------
module brs_sqrt #(
  parameter int RootW = 17,
  parameter int Lanes = 1,
  parameter int SideW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2*RootW-1:0]   rad_i [Lanes],
  input  logic [SideW-1:0]     side_i,
  output logic                 valid_o,
  output logic [RootW-1:0]     root_o [Lanes],
  output logic [SideW-1:0]     side_o
);

  localparam int RemW = RootW + 2;

  logic [2*RootW-1:0] rad_q  [RootW][Lanes];
  logic [2*RootW-1:0] rad_d  [RootW][Lanes];
  logic [RemW-1:0]    rem_q  [RootW][Lanes];
  logic [RemW-1:0]    rem_d  [RootW][Lanes];
  logic [RootW-1:0]   root_q [RootW][Lanes];
  logic [RootW-1:0]   root_d [RootW][Lanes];
  logic [SideW-1:0]   side_q [RootW];
  logic [RootW-1:0]   vld_q;

  always_comb begin
    logic [2*RootW-1:0] rad_c;
    logic [RemW-1:0]    rem_c;
    logic [RootW-1:0]   root_c;
    logic [RemW-1:0]    t_c;
    logic [RemW-1:0]    trial_c;
    for (int k = 0; k < RootW; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        if (k == 0) begin
          rad_c  = rad_i[l];
          rem_c  = '0;
          root_c = '0;
        end else begin
          rad_c  = rad_q[k-1][l];
          rem_c  = rem_q[k-1][l];
          root_c = root_q[k-1][l];
        end
        // bring down the next bit pair and try root*4+1
        t_c     = {rem_c[RemW-3:0], rad_c[2*RootW-1 -: 2]};
        trial_c = {root_c, 2'b01};
        rad_d[k][l] = rad_c << 2;
        if (t_c >= trial_c) begin
          rem_d[k][l]  = t_c - trial_c;
          root_d[k][l] = {root_c[RootW-2:0], 1'b1};
        end else begin
          rem_d[k][l]  = t_c;
          root_d[k][l] = {root_c[RootW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q     <= rad_d;
      rem_q     <= rem_d;
      root_q    <= root_d;
      side_q[0] <= side_i;
      for (int k = 1; k < RootW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootW-2:0], valid_i};
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      root_o[l] = root_q[RootW-1][l];
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

// ===== sv/brs_div.sv =====
// ----------------------------------------------------------------------------
// brs_div
// pipelined unsigned restoring divider, one quotient bit per stage,
// several numerators over one shared divisor
// ----------------------------------------------------------------------------
module brs_div #(
  parameter int QuotW = 34,
  parameter int DivW  = 17,
  parameter int Lanes = 2,
  parameter int SideW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [QuotW-1:0]   num_i [Lanes],
  input  logic [DivW-1:0]    den_i,
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output logic [QuotW-1:0]   quot_o [Lanes],
  output logic [SideW-1:0]   side_o
);

  // numerator bits shift out at the top while quotient bits shift in below
  logic [QuotW-1:0] nq_q  [QuotW][Lanes];
  logic [QuotW-1:0] nq_d  [QuotW][Lanes];
  logic [DivW-1:0]  rem_q [QuotW][Lanes];
  logic [DivW-1:0]  rem_d [QuotW][Lanes];
  logic [DivW-1:0]  den_q [QuotW];
  logic [SideW-1:0] side_q [QuotW];
  logic [QuotW-1:0] vld_q;

  always_comb begin
    logic [QuotW-1:0] nq_c;
    logic [DivW-1:0]  rem_c;
    logic [DivW-1:0]  den_c;
    logic [DivW:0]    t_c;
    logic [DivW:0]    diff_c;
    for (int k = 0; k < QuotW; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        if (k == 0) begin
          nq_c  = num_i[l];
          rem_c = '0;
          den_c = den_i;
        end else begin
          nq_c  = nq_q[k-1][l];
          rem_c = rem_q[k-1][l];
          den_c = den_q[k-1];
        end
        t_c    = {rem_c, nq_c[QuotW-1]};
        diff_c = t_c - {1'b0, den_c};
        if (t_c >= {1'b0, den_c}) begin
          rem_d[k][l] = diff_c[DivW-1:0];
          nq_d[k][l]  = {nq_c[QuotW-2:0], 1'b1};
        end else begin
          rem_d[k][l] = t_c[DivW-1:0];
          nq_d[k][l]  = {nq_c[QuotW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_q      <= nq_d;
      rem_q     <= rem_d;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int k = 1; k < QuotW; k++) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuotW-2:0], valid_i};
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      quot_o[l] = nq_q[QuotW-1][l];
    end
  end

  assign valid_o = vld_q[QuotW-1];
  assign side_o  = side_q[QuotW-1];

endmodule

// ===== tb/sv/tb_biquadratic_root_solver_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_biquadratic_root_solver_top
// checks the biquadratic root solver against a fixed-point root predictor;
// directed corner sets, then random coefficient sets with random stalls on
// both stream sides, every result compared field by field in order
// ----------------------------------------------------------------------------

class root_scoreboard;

  typedef struct packed {
    logic [2:0]  status;
    logic [25:0] r1;
    logic [25:0] r2;
    logic [25:0] r3;
    logic [25:0] r4;
  } roots_t;

  roots_t pending_roots[$];
  int     n_mismatch;
  int     n_checked;
  int     n_noted;
  int     status_seen[6];

  // floor(sqrt(v * 2^s))
  static function automatic longint unsigned sqrt_scaled(longint unsigned v, int s);
    longint unsigned rem;
    longint unsigned root;
    logic [127:0]    wide;
    logic [1:0]      pair;
    rem  = 0;
    root = 0;
    wide = 128'(v) << s;
    for (int p = 47; p >= 0; p--) begin
      pair = wide[2*p +: 2];
      rem  = (rem << 2) | pair;
      root = root << 1;
      if (rem >= ((root << 1) | 1)) begin
        rem  = rem - ((root << 1) | 1);
        root = root | 1;
      end
    end
    return root;
  endfunction

  static function automatic int push_roots(longint y, ref longint x[4], input int n);
    longint unsigned r;
    if (y < 0 || n > 3) return n;
    if (y == 0) begin
      x[n] = 0;
      return n + 1;
    end
    r = sqrt_scaled(y, brs_pkg::FRAC_BITS);
    if (r > 33554431) r = 33554431;
    x[n]     = -longint'(r);
    x[n + 1] = longint'(r);
    return n + 2;
  endfunction

  function void note_coefs(logic signed [15:0] qa, logic signed [15:0] qb,
                           logic signed [15:0] qc);
    longint a, b, c, d, two_a, s, unit;
    longint x[4];
    int     n;
    int     st;
    roots_t e;
    a = qa; b = qb; c = qc;
    unit = longint'(1) << brs_pkg::FRAC_BITS;
    x = '{0, 0, 0, 0};
    n = 0;
    if (a == 0) begin
      if (b == 0) st = (c == 0) ? brs_pkg::STATUS_UNDET : brs_pkg::STATUS_NONE;
      else begin
        n  = push_roots((-c * unit) / b, x, 0);
        st = n;
      end
    end else begin
      d = b * b - 4 * a * c;
      two_a = 2 * a;
      if (d < 0) st = brs_pkg::STATUS_NONE;
      else if (d == 0) begin
        n  = push_roots((-b * unit) / two_a, x, 0);
        st = n;
      end else begin
        s  = sqrt_scaled(d, 2 * brs_pkg::FRAC_BITS);
        n  = push_roots((-b * unit - s) / two_a, x, 0);
        n  = push_roots((-b * unit + s) / two_a, x, n);
        st = n;
      end
    end
    e.status = st[2:0];
    e.r1 = x[0][25:0];
    e.r2 = x[1][25:0];
    e.r3 = x[2][25:0];
    e.r4 = x[3][25:0];
    pending_roots.push_back(e);
    n_noted++;
    status_seen[st]++;
  endfunction

  function void check_roots(logic [111:0] tdata);
    roots_t got, want;
    got.status = tdata[2:0];
    got.r1 = tdata[28:3];
    got.r2 = tdata[54:29];
    got.r3 = tdata[80:55];
    got.r4 = tdata[106:81];
    n_checked++;
    if (pending_roots.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= 10) $display("unexpected result transfer: %h", tdata);
      return;
    end
    want = pending_roots.pop_front();
    if (got !== want || tdata[111:107] !== 5'd0) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("root mismatch #%0d: exp st=%0d %h %h %h %h  got st=%0d %h %h %h %h",
                 n_checked, want.status, want.r1, want.r2, want.r3, want.r4,
                 got.status, got.r1, got.r2, got.r3, got.r4);
    end
  endfunction

endclass

module tb_biquadratic_root_solver_top;

  localparam int LATENCY   = 3 * brs_pkg::FRAC_BITS + 48;
  localparam int N_RANDOM  = 1150;
  localparam int MAX_CYCLE = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [47:0]  s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [111:0] m_axis_tdata_o;

  root_scoreboard sb = new();
  int  cycle_count = 0;
  bit  no_idle = 1'b0;

  biquadratic_root_solver_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // sample on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o)
      sb.note_coefs(s_axis_tdata_i[15:0], s_axis_tdata_i[31:16], s_axis_tdata_i[47:32]);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_roots(m_axis_tdata_o);
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) m_axis_tready_i <= 1'b0;
    else m_axis_tready_i <= no_idle || ($urandom_range(99) >= 27);
  end

  // tvalid stays high between back-to-back transfers and drops only while idling
  task automatic send_coefs(logic [15:0] qa, logic [15:0] qb, logic [15:0] qc);
    while (!no_idle && $urandom_range(99) < 27) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {qc, qb, qa};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    while (sb.pending_roots.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(5))
      0: return 16'($urandom_range(7)) - 16'd3;
      1: return 16'($urandom_range(255)) - 16'd128;
      2: return $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(3)) :
                                    16'h8000 + 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] qa, qb, qc;
    int k;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners: undetermined, no solution, linear, double root,
    // negative discriminant, four roots, extremes
    send_coefs(16'd0, 16'd0, 16'd0);
    send_coefs(16'd0, 16'd0, 16'd5);
    send_coefs(16'd0, 16'd2, -16'd8);
    send_coefs(16'd0, 16'd2, 16'd8);
    send_coefs(16'd0, 16'd3, 16'd0);
    send_coefs(16'd1, -16'd2, 16'd1);
    send_coefs(16'd1, 16'd2, 16'd1);
    send_coefs(16'd1, 16'd0, 16'd0);
    send_coefs(16'd1, 16'd1, 16'd1);
    send_coefs(16'd1, -16'd5, 16'd4);
    send_coefs(16'd1, -16'd3, 16'd0);
    send_coefs(16'd1, 16'd3, -16'd4);
    send_coefs(-16'd1, 16'd5, -16'd4);
    send_coefs(16'd3, -16'd7, 16'd1);
    send_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h7FFF, 16'h7FFF);
    send_coefs(16'd1, 16'h8000, 16'h7FFF);
    send_coefs(16'd1, 16'h8000, 16'd0);
    send_coefs(16'h0001, 16'h7FFF, 16'h8000);
    send_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_coefs(16'd0, 16'h8000, 16'h7FFF);
    s_axis_tvalid_i <= 1'b0;

    // sender hold-off until the pipeline is empty
    drain_results();

    for (k = 0; k < N_RANDOM; k++) begin
      no_idle = (k >= 300 && k < 450);
      qa = (($urandom_range(9) == 0) ? 16'd0 : rand_coef());
      qb = rand_coef();
      qc = rand_coef();
      // bias toward real positive y: opposite sign of b vs a, c same sign as a
      if ($urandom_range(2) == 0 && qa != 0) begin
        qb = ($signed(qa) > 0) ? -(qb & 16'h3FFF) : (qb & 16'h3FFF);
        qc = ($signed(qa) > 0) ? (qc & 16'h00FF) : -(qc & 16'h00FF);
      end
      send_coefs(qa, qb, qc);
    end
    s_axis_tvalid_i <= 1'b0;
    no_idle = 1'b0;

    drain_results();
    repeat (LATENCY + 10) @(negedge clk_i);
    $display("%0d coefficient sets checked; status counts 0..5: %0d %0d %0d %0d %0d %0d",
             sb.n_checked, sb.status_seen[0], sb.status_seen[1], sb.status_seen[2],
             sb.status_seen[3], sb.status_seen[4], sb.status_seen[5]);
    if (sb.n_mismatch == 0 && sb.pending_roots.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.n_mismatch,
               sb.pending_roots.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/brs_pkg.sv
sv/brs_sqrt.sv
sv/brs_div.sv
sv/biquadratic_root_solver_top.sv
tb/sv/tb_biquadratic_root_solver_top.sv
